### rtl/hsfd_pkg.sv
package hsfd_pkg;

   // Frame layout: temperature word, its CRC, humidity word, its CRC.
   localparam int FRAME_BYTES = 6;
   localparam int STORE_DEPTH = FRAME_BYTES - 1;
   localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
   localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

   localparam int TEMP_MSB_POS = 0;
   localparam int TEMP_LSB_POS = 1;
   localparam int TEMP_CRC_POS = 2;
   localparam int HUM_MSB_POS  = 3;
   localparam int HUM_LSB_POS  = 4;
   localparam int HUM_CRC_POS  = 5;

   localparam int JOB_QUEUE_DEPTH    = 4;
   localparam int RESULT_QUEUE_DEPTH = 4;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Fixed-point conversion constants (hundredths of kelvin / percent).
   localparam logic [15:0] TEMP_OFFSET = 16'd22815;
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [13:0] HUM_SPAN    = 14'd12500;
   localparam logic [15:0] HUM_OFFSET  = 16'd600;
   localparam logic [15:0] HUM_MAX     = 16'd10000;

   localparam int TEMP_PROD_W = 31;
   localparam int HUM_PROD_W  = 30;

   typedef enum logic [1:0] {
      ACTION_START    = 2'd0,
      ACTION_DATA     = 2'd1,
      ACTION_BUS_FAIL = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      FAIL_NONE = 2'd0,
      FAIL_BUS  = 2'd1,
      FAIL_CRC  = 2'd2
   } failure_kind_type;

   typedef struct packed {
      failure_kind_type kind;
      logic [15:0]      temp_raw;
      logic [15:0]      hum_raw;
   } job_type;

   typedef struct packed {
      logic [15:0]      temperature_centikelvin;
      logic [13:0]      humidity_centipercent;
      logic             reading_present;
      logic             measurement_valid;
      failure_kind_type failure_kind;
      logic [31:0]      failure_total;
   } result_type;

   // One byte of CRC-8, MSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/hsfd_fifo.sv
module hsfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/hsfd_front.sv
module hsfd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        action,
   input  logic [7:0]        data_byte,
   output logic              job_push,
   output hsfd_pkg::job_type job
);
   import hsfd_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         crc_ff, crc_in;
   logic               temp_ok_ff, temp_ok_in;
   logic [7:0]         store_ff [STORE_DEPTH];
   logic               store_we;
   logic               frame_ok;

   // The CRC runs along with the bytes, so the sixth byte only needs a compare.
   assign frame_ok = temp_ok_ff && (crc_ff == data_byte);

   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      temp_ok_in = temp_ok_ff;
      store_we   = 1'b0;
      job_push   = 1'b0;
      job.kind     = FAIL_NONE;
      job.temp_raw = {store_ff[TEMP_MSB_POS], store_ff[TEMP_LSB_POS]};
      job.hum_raw  = {store_ff[HUM_MSB_POS], store_ff[HUM_LSB_POS]};
      if (accept) begin
         unique case (action)
            ACTION_START: begin
               count_in = '0;
            end
            ACTION_DATA: begin
               if (count_ff < COUNT_W'(STORE_DEPTH)) begin
                  store_we = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
                  if (count_ff == COUNT_W'(TEMP_MSB_POS) ||
                      count_ff == COUNT_W'(HUM_MSB_POS)) begin
                     crc_in = crc8_byte(CRC_INIT, data_byte);
                  end else if (count_ff == COUNT_W'(TEMP_CRC_POS)) begin
                     temp_ok_in = (crc_ff == data_byte);
                  end else begin
                     crc_in = crc8_byte(crc_ff, data_byte);
                  end
               end else if (count_ff == COUNT_W'(HUM_CRC_POS)) begin
                  count_in = COUNT_W'(FRAME_BYTES);
                  job_push = 1'b1;
                  job.kind = frame_ok ? FAIL_NONE : FAIL_CRC;
               end
            end
            ACTION_BUS_FAIL: begin
               count_in = COUNT_W'(FRAME_BYTES);
               job_push = 1'b1;
               job.kind = FAIL_BUS;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_ff     <= CRC_INIT;
         temp_ok_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         temp_ok_ff <= temp_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff[STORE_IDX_W-1:0]] <= data_byte;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(FRAME_BYTES))
      else $error("frame byte count out of range");

   a_sixth_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && action == ACTION_DATA && count_ff == COUNT_W'(HUM_CRC_POS))
      |-> job_push ##1 count_ff == COUNT_W'(FRAME_BYTES))
      else $error("sixth byte did not conclude the frame");

   a_push_cause: assert property (@(posedge clock) disable iff (reset)
      job_push |-> accept && (action == ACTION_BUS_FAIL ||
                              count_ff == COUNT_W'(HUM_CRC_POS)))
      else $error("job issued without a concluding item");
`endif

endmodule

### rtl/hsfd_back.sv
module hsfd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  hsfd_pkg::job_type    job,
   input  logic                 job_empty,
   output logic                 job_pop,
   input  logic                 out_full,
   output logic                 out_push,
   output hsfd_pkg::result_type result
);
   import hsfd_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   failure_kind_type       s1_kind_ff;
   logic [TEMP_PROD_W-1:0] s1_temp_prod_ff;
   logic [HUM_PROD_W-1:0]  s1_hum_prod_ff;

   logic [15:0] temp_held_ff, temp_held_in;
   logic [13:0] hum_held_ff, hum_held_in;
   logic        have_ff, have_in;
   logic [31:0] fail_ff, fail_in;

   logic [15:0] temp_q, hum_q, hum_sub;
   logic [15:0] temp_value;
   logic [13:0] hum_value;
   logic        success;

   // floor(x / 65535) for quotients below 65536: (x + (x >> 16) + 1) >> 16.
   function automatic logic [15:0] div_full_scale(input logic [TEMP_PROD_W-1:0] x);
      logic [TEMP_PROD_W:0] s;
      s = {1'b0, x} + (TEMP_PROD_W + 1)'(x >> 16) + (TEMP_PROD_W + 1)'(1);
      return s[TEMP_PROD_W:16];
   endfunction

   assign out_push    = s1_valid_ff && !out_full;
   assign job_pop     = !job_empty && (!s1_valid_ff || !out_full);
   assign s1_valid_in = job_pop ? 1'b1 : (out_push ? 1'b0 : s1_valid_ff);
   assign success     = (s1_kind_ff == FAIL_NONE);

   always_comb begin
      temp_q     = div_full_scale(s1_temp_prod_ff);
      hum_q      = div_full_scale(TEMP_PROD_W'(s1_hum_prod_ff));
      temp_value = TEMP_OFFSET + temp_q;
      hum_sub    = hum_q - HUM_OFFSET;
      if (hum_q <= HUM_OFFSET) begin
         hum_value = '0;
      end else if (hum_sub > HUM_MAX) begin
         hum_value = HUM_MAX[13:0];
      end else begin
         hum_value = hum_sub[13:0];
      end
   end

   always_comb begin
      temp_held_in = temp_held_ff;
      hum_held_in  = hum_held_ff;
      have_in      = have_ff;
      fail_in      = fail_ff;
      if (out_push) begin
         if (success) begin
            temp_held_in = temp_value;
            hum_held_in  = hum_value;
            have_in      = 1'b1;
         end else begin
            fail_in = fail_ff + 32'd1;
         end
      end
      result.temperature_centikelvin = temp_held_in;
      result.humidity_centipercent   = hum_held_in;
      result.reading_present         = have_in;
      result.measurement_valid       = success;
      result.failure_kind            = s1_kind_ff;
      result.failure_total           = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         temp_held_ff <= '0;
         hum_held_ff  <= '0;
         have_ff      <= 1'b0;
         fail_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         temp_held_ff <= temp_held_in;
         hum_held_ff  <= hum_held_in;
         have_ff      <= have_in;
         fail_ff      <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         s1_kind_ff      <= job.kind;
         s1_temp_prod_ff <= TEMP_PROD_W'(job.temp_raw) * TEMP_PROD_W'(TEMP_SPAN);
         s1_hum_prod_ff  <= HUM_PROD_W'(job.hum_raw) * HUM_PROD_W'(HUM_SPAN);
      end
   end

`ifndef NO_ASSERTIONS
   a_push_needs_stage: assert property (@(posedge clock) disable iff (reset)
      out_push |-> s1_valid_ff)
      else $error("result written without a job in the stage");

   a_fail_count: assert property (@(posedge clock) disable iff (reset)
      (out_push && s1_kind_ff != FAIL_NONE) |=> fail_ff == $past(fail_ff) + 32'd1)
      else $error("failure count did not advance on a failure");

   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      !(out_push && s1_kind_ff != FAIL_NONE) |=> $stable(fail_ff))
      else $error("failure count moved without a failure");

   a_have_sticky: assert property (@(posedge clock) disable iff (reset)
      have_ff |=> have_ff)
      else $error("reading present flag dropped");
`endif

endmodule

### rtl/humidity_sensor_frame_decoder.sv
// Channel   | Direction | Handshake      | Payload
// req_      | in        | push / full    | action, data_byte
// rsp_      | out       | pop / empty    | temperature_centikelvin, humidity_centipercent,
//           |           |                | reading_present, measurement_valid,
//           |           |                | failure_kind, failure_total
//
// One input item can be taken on every cycle; full rises only when the job queue between
// the front and back ends is full, which happens only while results back up.
// A concluding item (the sixth byte or a bus failure) passes through the job queue and then
// the multiply stage of the back end before it reaches the result queue.
// Reset is synchronous and active high; it clears the byte count, the held readings, the
// failure count and both queues. No clearing pass is needed.
// A stalled result side fills the result queue, then holds the multiply stage, then fills
// the job queue; items that conclude nothing keep being taken until the job queue is full.
module humidity_sensor_frame_decoder #(
   parameter int JOB_QUEUE_DEPTH    = hsfd_pkg::JOB_QUEUE_DEPTH,
   parameter int RESULT_QUEUE_DEPTH = hsfd_pkg::RESULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_temperature_centikelvin,
   output logic [13:0] rsp_humidity_centipercent,
   output logic        rsp_reading_present,
   output logic        rsp_measurement_valid,
   output logic [1:0]  rsp_failure_kind,
   output logic [31:0] rsp_failure_total
);
   import hsfd_pkg::*;

   logic       req_accept;
   logic       job_push, job_pop, job_full, job_empty;
   job_type    job_in, job_out;
   logic       res_push, res_full;
   result_type res_in, res_out;

   // A transfer on the request side is taken whenever the job queue has room.
   assign req_full   = job_full;
   assign req_accept = req_push && !req_full;

   // The front end tracks the frame position, stores the data bytes and runs the CRC
   // as the bytes come in; it issues one job per concluding item.
   hsfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .action    (req_action),
      .data_byte (req_data_byte),
      .job_push  (job_push),
      .job       (job_in)
   );

   // Short queue that decouples frame collection from conversion.
   hsfd_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   // The back end scales the raw words, keeps the last good readings and the failure
   // count, and composes the result.
   hsfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_out),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .out_full  (res_full),
      .out_push  (res_push),
      .result    (res_in)
   );

   // Results wait here so the back end keeps working while the consumer stalls.
   hsfd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out),
      .empty     (rsp_empty)
   );

   assign rsp_temperature_centikelvin = res_out.temperature_centikelvin;
   assign rsp_humidity_centipercent   = res_out.humidity_centipercent;
   assign rsp_reading_present         = res_out.reading_present;
   assign rsp_measurement_valid       = res_out.measurement_valid;
   assign rsp_failure_kind            = res_out.failure_kind;
   assign rsp_failure_total           = res_out.failure_total;

endmodule
